// ===== hw/rtl/shfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shfd_pkg
// Codes, sync characters and types shared by the sync-header frame deframer.
// ----------------------------------------------------------------------------
package shfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;

  localparam logic [BYTE_W-1:0] SYNC_0 = 8'h55;  // 'U'
  localparam logic [BYTE_W-1:0] SYNC_1 = 8'h4E;  // 'N'
  localparam logic [BYTE_W-1:0] SYNC_2 = 8'h45;  // 'E'
  localparam logic [BYTE_W-1:0] SYNC_3 = 8'h52;  // 'R'
  localparam logic [BYTE_W-1:0] COLON  = 8'h3A;  // ':'

  // checksum seed: all fixed header characters
  localparam logic [BYTE_W-1:0] HDR_CHECK = SYNC_0 ^ SYNC_1 ^ SYNC_2 ^ SYNC_3 ^ COLON;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'd0,
    ST_N     = 3'd1,
    ST_E     = 3'd2,
    ST_R     = 3'd3,
    ST_LEN   = 3'd4,
    ST_COLON = 3'd5,
    ST_BODY  = 3'd6
  } hunt_state_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] position;
    logic [BYTE_W-1:0] data_byte;
  } result_t;

endpackage : shfd_pkg
`default_nettype wire

// ===== hw/rtl/sync_header_frame_deframer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_header_frame_deframer_core
// Hunts for the 'U' 'N' 'E' 'R' <len> ':' header, passes payload bytes out
// with their index and reports the XOR checksum result at frame end.
// ----------------------------------------------------------------------------
// channel  dir  tdata                               tuser
// s_*      in   [7:0] rx_byte                       -
// m_*      out  [7:0] data_byte, [15:8] position    [1:0] kind
//
// One byte is taken per cycle while s_tready is high; its result is registered
// in the output register. A skid register behind it keeps the input side open
// for one more request while the output stalls; s_tready drops only when both
// hold a result. Header bytes and mismatches give no result.
// rst is synchronous and returns the block to hunting for 'U'.
// ----------------------------------------------------------------------------
module sync_header_frame_deframer_core
  import shfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [2*BYTE_W-1:0]    m_tdata,   // [7:0] data_byte, [15:8] position
  output logic [KIND_W-1:0]      m_tuser    // [1:0] kind
);

  hunt_state_t       hunt_state, hunt_state_next;
  logic [BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [BYTE_W-1:0] running_check, running_check_next;
  logic [BYTE_W-1:0] payload_index, payload_index_next;
  logic [BYTE_W-1:0] left_dec;

  logic    res_valid;
  result_t res;
  result_t out_reg, skid_reg;
  logic    skid_valid;
  logic    accept, out_free;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !skid_valid;
  assign left_dec = bytes_left - 8'd1;

  function automatic hunt_state_t first_char(input logic [BYTE_W-1:0] b);
    return (b == SYNC_0) ? ST_N : ST_HUNT;
  endfunction

  always_comb begin
    hunt_state_next    = hunt_state;
    bytes_left_next    = bytes_left;
    running_check_next = running_check;
    payload_index_next = payload_index;
    res_valid          = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.data_byte      = s_tdata;
    res.position       = payload_index;
    unique case (hunt_state)
      ST_N:     hunt_state_next = (s_tdata == SYNC_1) ? ST_E : first_char(s_tdata);
      ST_E:     hunt_state_next = (s_tdata == SYNC_2) ? ST_R : first_char(s_tdata);
      ST_R:     hunt_state_next = (s_tdata == SYNC_3) ? ST_LEN : first_char(s_tdata);
      ST_LEN: begin
        bytes_left_next = s_tdata;
        hunt_state_next = ST_COLON;
      end
      ST_COLON: begin
        if (s_tdata == COLON) begin
          hunt_state_next    = ST_BODY;
          payload_index_next = '0;
          running_check_next = HDR_CHECK ^ bytes_left;
        end else begin
          hunt_state_next = first_char(s_tdata);
        end
      end
      ST_BODY: begin
        bytes_left_next = left_dec;
        res_valid       = 1'b1;
        if (left_dec != '0) begin
          payload_index_next = payload_index + 8'd1;
          running_check_next = running_check ^ s_tdata;
        end else begin
          hunt_state_next = ST_HUNT;
          res.kind        = (running_check == s_tdata) ? KIND_GOOD : KIND_BAD;
        end
      end
      default:  hunt_state_next = first_char(s_tdata);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_state    <= ST_HUNT;
      bytes_left    <= '0;
      running_check <= '0;
      payload_index <= '0;
    end else if (accept) begin
      hunt_state    <= hunt_state_next;
      bytes_left    <= bytes_left_next;
      running_check <= running_check_next;
      payload_index <= payload_index_next;
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid_reg : res;
    end
    if (!out_free && accept && res_valid) begin
      skid_reg <= res;
    end
  end

  assign m_tdata = {out_reg.position, out_reg.data_byte};
  assign m_tuser = out_reg.kind;

endmodule : sync_header_frame_deframer_core
`default_nettype wire

// ===== hw/rtl/shfd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shfd_checker
// Port-level checks for the sync-header frame deframer, bound to the core.
// ----------------------------------------------------------------------------
module shfd_checker
  import shfd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [2*BYTE_W-1:0] m_tdata,
  input wire logic [KIND_W-1:0] m_tuser
);

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_PAYLOAD || m_tuser == KIND_GOOD || m_tuser == KIND_BAD))
    else $error("result kind out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid ##1 m_tvalid |-> $past(s_tvalid && s_tready))
    else $error("result without a request");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input blocked while output empty");

  // a taken result always frees room for the next request
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> s_tready)
    else $error("input still blocked after result taken");

endmodule : shfd_checker

bind sync_header_frame_deframer_core shfd_checker u_shfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
